>>> hw/rtl/tsi_pkg.sv
// shared constants and the order-key function for the three-way sorted intersection
package tsi_pkg;
	localparam logic CMD_APPEND = 1'b0;
	localparam logic CMD_RUN    = 1'b1;
	localparam int   NUM_LISTS  = 3;
	localparam logic [1:0] LIST_NONE = 2'd3;

	// order key: flip sign bit so unsigned compare gives signed order
	function automatic logic [31:0] order_key(input logic [31:0] v);
		order_key = v ^ 32'h8000_0000;
	endfunction
endpackage

>>> hw/rtl/tsi_list_mem.sv
// list storage memory: one write port, one registered read port
module tsi_list_mem #(
	parameter int AW = 8,
	parameter int DEPTH = 192
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [31:0]   wdata,
	input  logic [AW-1:0] raddr,
	output logic [31:0]   rdata
);
	logic [31:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule

>>> hw/rtl/three_way_sorted_intersection.sv
// top level of the three-way sorted intersection
// Three lists of up to LIST_DEPTH signed IDs live in one single-port-read memory.
// An append (command 0) inserts its value in sorted place by a walk from the
// list's end down, one read and one write per stored entry it moves. Appends
// to a full list are dropped and set the sticky overflow flag; list number 3
// is ignored. A run (command 1) merges the three sorted lists, reading one
// entry at a time through the memory port, and emits each common value once in
// ascending order, the last one marked; with nothing common a single item with
// none_found is given. Afterwards the lists and the flag are empty again.
module three_way_sorted_intersection #(
	parameter int LIST_DEPTH = 64
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic               command,
	input  logic [1:0]         list_number,
	input  logic signed [31:0] customer_id,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [31:0] common_value,
	output logic               last_common,
	output logic               none_found,
	output logic               overflow_seen
);
	localparam int CW    = $clog2(LIST_DEPTH + 1);
	localparam int IW    = $clog2(LIST_DEPTH);
	localparam int DEPTH = 3 * LIST_DEPTH;
	localparam int AW    = $clog2(DEPTH);

	localparam logic [3:0] ST_IDLE  = 4'd0;
	localparam logic [3:0] ST_IRD   = 4'd1; // issue read of pos-1
	localparam logic [3:0] ST_IWAIT = 4'd2; // compare read data
	localparam logic [3:0] ST_RRD   = 4'd3; // issue read of current list head
	localparam logic [3:0] ST_RWAIT = 4'd4; // latch head
	localparam logic [3:0] ST_RCMP  = 4'd5; // decide
	localparam logic [3:0] ST_EMIT  = 4'd6; // result waiting
	localparam logic [3:0] ST_SKRD  = 4'd7; // skip-equal read
	localparam logic [3:0] ST_SKWT  = 4'd8;
	localparam logic [3:0] ST_FIN   = 4'd9;

	logic [3:0]    state_q;
	logic [CW-1:0] cnt_q [3];
	logic          ovf_q;
	logic [1:0]    lst_q;
	logic [31:0]   val_q;
	logic [CW-1:0] pos_q;
	logic [CW-1:0] idx_q [3];
	logic [31:0]   head_q [3];
	logic [1:0]    rl_q;    // list being fetched
	logic [2:0]    need_q;  // heads to refetch
	logic [31:0]   match_q;
	logic          have_q;  // a match waits to be emitted
	logic          found_q;
	logic          fin_q;

	logic          we;
	logic [AW-1:0] waddr, raddr;
	logic [31:0]   wdata, rdata;

	tsi_list_mem #(.AW(AW), .DEPTH(DEPTH)) u_mem (
		.clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
		.raddr(raddr), .rdata(rdata)
	);

	function automatic logic [AW-1:0] addr_of(input logic [1:0] l, input logic [CW-1:0] i);
		addr_of = AW'(l) * AW'(LIST_DEPTH) + AW'(i[IW-1:0]);
	endfunction

	logic [CW-1:0] pos_m1;
	assign pos_m1 = pos_q - CW'(1);

	// any list exhausted
	logic done_w;
	assign done_w = (idx_q[0] >= cnt_q[0]) || (idx_q[1] >= cnt_q[1]) ||
		(idx_q[2] >= cnt_q[2]);

	logic [1:0] first_need;
	always_comb begin
		first_need = 2'd0;
		if (need_q[0]) first_need = 2'd0;
		else if (need_q[1]) first_need = 2'd1;
		else first_need = 2'd2;
	end

	logic [31:0] mx;
	always_comb begin
		mx = tsi_pkg::order_key(head_q[0]);
		if (tsi_pkg::order_key(head_q[1]) > mx) mx = tsi_pkg::order_key(head_q[1]);
		if (tsi_pkg::order_key(head_q[2]) > mx) mx = tsi_pkg::order_key(head_q[2]);
	end

	always_comb begin
		we    = 1'b0;
		waddr = addr_of(lst_q, pos_q);
		wdata = val_q;
		raddr = addr_of(rl_q, idx_q[rl_q]);
		if (state_q == ST_IRD) raddr = addr_of(lst_q, pos_m1);
		if (state_q == ST_IWAIT) begin
			we = 1'b1;
			if (pos_q != '0 && tsi_pkg::order_key(rdata) > tsi_pkg::order_key(val_q))
				wdata = rdata;
		end
	end

	assign in_ready = (state_q == ST_IDLE);
	assign out_valid = (state_q == ST_EMIT);
	assign common_value = found_q ? match_q : 32'sd0;
	assign none_found = !found_q;
	assign last_common = fin_q;
	assign overflow_seen = ovf_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			ovf_q   <= 1'b0;
			have_q  <= 1'b0;
			found_q <= 1'b0;
			fin_q   <= 1'b0;
			need_q  <= '0;
			rl_q    <= '0;
			for (int i = 0; i < 3; i++) begin
				cnt_q[i] <= '0;
				idx_q[i] <= '0;
			end
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						lst_q <= list_number;
						val_q <= customer_id;
						if (command == tsi_pkg::CMD_RUN) begin
							for (int i = 0; i < 3; i++) idx_q[i] <= '0;
							need_q  <= 3'b111;
							have_q  <= 1'b0;
							found_q <= 1'b0;
							state_q <= ST_RCMP;
						end else if (list_number != tsi_pkg::LIST_NONE) begin
							if (cnt_q[list_number] == CW'(LIST_DEPTH)) ovf_q <= 1'b1;
							else begin
								pos_q   <= cnt_q[list_number];
								state_q <= ST_IRD;
							end
						end
					end
				end
				ST_IRD: state_q <= ST_IWAIT;
				ST_IWAIT: begin
					if (pos_q != '0 && tsi_pkg::order_key(rdata) > tsi_pkg::order_key(val_q)) begin
						pos_q   <= pos_m1;
						state_q <= ST_IRD;
					end else begin
						cnt_q[lst_q] <= cnt_q[lst_q] + CW'(1);
						state_q <= ST_IDLE;
					end
				end
				ST_RCMP: begin
					if (done_w) begin
						if (have_q) begin
							fin_q <= 1'b1;
							state_q <= ST_EMIT;
						end else if (!found_q) begin
							fin_q <= 1'b1;
							state_q <= ST_EMIT;
						end else state_q <= ST_FIN;
					end else if (need_q != '0) begin
						rl_q    <= first_need;
						state_q <= ST_RRD;
					end else if (head_q[0] == head_q[1] && head_q[0] == head_q[2]) begin
						if (have_q) begin
							// previous match goes out once another one is known
							fin_q   <= 1'b0;
							state_q <= ST_EMIT;
						end else begin
							match_q <= head_q[0];
							have_q  <= 1'b1;
							found_q <= 1'b1;
							rl_q    <= 2'd0;
							state_q <= ST_SKRD;
						end
					end else begin
						for (int i = 0; i < 3; i++)
							if (tsi_pkg::order_key(head_q[i]) < mx) begin
								idx_q[i]  <= idx_q[i] + CW'(1);
								need_q[i] <= 1'b1;
							end
					end
				end
				ST_RRD: state_q <= ST_RWAIT;
				ST_RWAIT: begin
					head_q[rl_q] <= rdata;
					need_q[rl_q] <= 1'b0;
					state_q <= ST_RCMP;
				end
				// skip entries equal to the match in list rl_q
				ST_SKRD: begin
					if (idx_q[rl_q] >= cnt_q[rl_q]) begin
						if (rl_q == 2'd2) begin
							need_q  <= 3'b111;
							state_q <= ST_RCMP;
						end else rl_q <= rl_q + 2'd1;
					end else state_q <= ST_SKWT;
				end
				ST_SKWT: begin
					if (rdata == match_q) begin
						idx_q[rl_q] <= idx_q[rl_q] + CW'(1);
						state_q <= ST_SKRD;
					end else if (rl_q == 2'd2) begin
						need_q  <= 3'b111;
						state_q <= ST_RCMP;
					end else begin
						rl_q    <= rl_q + 2'd1;
						state_q <= ST_SKRD;
					end
				end
				ST_EMIT: begin
					if (out_ready) begin
						have_q <= 1'b0;
						state_q <= fin_q ? ST_FIN : ST_RCMP;
					end
				end
				ST_FIN: begin
					for (int i = 0; i < 3; i++) cnt_q[i] <= '0;
					ovf_q   <= 1'b0;
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule
